### design/range_mode_qualifier_unit_defines.svh
// ----------------------------------------------------------------------------
// Range mode qualifier assertion macros
// Shared wrappers for the concurrent checks of the range mode qualifier.
// ----------------------------------------------------------------------------
`ifndef RANGE_MODE_QUALIFIER_UNIT_DEFINES_SVH
`define RANGE_MODE_QUALIFIER_UNIT_DEFINES_SVH

// Check that is switched off while reset is high.
`define RMQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also holds during reset.
`define RMQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/rmq_pkg.sv
// ----------------------------------------------------------------------------
// Range mode qualifier package
// Widths, reset values and register indexes shared by the qualifier modules.
// ----------------------------------------------------------------------------
package rmq_pkg;

   localparam int DIST_W               = 11;
   localparam int RUN_W                = 4;
   localparam int WINDOW_DEPTH_DEFAULT = 5;

   localparam logic [RUN_W-1:0]  RUN_MAX = '1;

   // Reset values: 15.0 cm, 25.0 cm and 8.5 cm in 1/16 cm units.
   localparam logic [DIST_W-1:0] CONFINED_LIMIT_RESET = 11'd240;
   localparam logic [DIST_W-1:0] OPEN_LIMIT_RESET     = 11'd400;
   localparam logic [DIST_W-1:0] FRONT_SAFE_RESET     = 11'd136;
   localparam logic [RUN_W-1:0]  STABLE_NEEDED_RESET  = 4'd5;

   typedef enum logic [1:0] {
      CSR_CONFINED_LIMIT = 2'd0,
      CSR_OPEN_LIMIT     = 2'd1,
      CSR_FRONT_SAFE     = 2'd2,
      CSR_STABLE_NEEDED  = 2'd3
   } csr_index_type;

   typedef enum logic {
      MODE_LINE = 1'b0,
      MODE_MAZE = 1'b1
   } mode_type;

endpackage

### design/rmq_window.sv
// ----------------------------------------------------------------------------
// Range mode qualifier history window
// Circular history of one range channel with a running sum of its entries.
// ----------------------------------------------------------------------------
module rmq_window
   import rmq_pkg::*;
#(
   parameter  int WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT,
   localparam int SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1,
   localparam int SUM_W        = DIST_W + $clog2(WINDOW_DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              update,
   input  logic [SLOT_W-1:0] slot,
   input  logic [DIST_W-1:0] sample,
   output logic [SUM_W-1:0]  sum_next
);

   logic [DIST_W-1:0] window_ff [WINDOW_DEPTH];
   logic [SUM_W-1:0]  sum_ff;

   // The oldest entry leaves the sum as the new sample takes its slot.
   assign sum_next = sum_ff - SUM_W'(window_ff[slot]) + SUM_W'(sample);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            window_ff[i] <= '0;
         end
         sum_ff <= '0;
      end else if (update) begin
         window_ff[slot] <= sample;
         sum_ff          <= sum_next;
      end
   end

endmodule

### design/range_mode_qualifier_unit.sv
// ----------------------------------------------------------------------------
// Range mode qualifier
// Averages left, right and front range readings over a sliding window and
// switches between line following and maze navigation after a stable run.
// ----------------------------------------------------------------------------
// A request accepted into the input register moves on to the result register
// once the result channel is free to take it.
// Throughput: one request per cycle while the result channel is not stalled; the
// window sums and run counters update as a request moves between the registers.
// Reset clears the histories, sums, run counters, mode and both valid flags,
// and loads the threshold registers with their default values.
`include "range_mode_qualifier_unit_defines.svh"

module range_mode_qualifier_unit
   import rmq_pkg::*;
#(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   // Request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [DIST_W-1:0] req_left_range,
   input  logic [DIST_W-1:0] req_right_range,
   input  logic [DIST_W-1:0] req_front_range,
   // Result channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_mode,
   output logic              rsp_mode_changed,
   // Configuration port
   input  logic              csr_write_en,
   input  logic [1:0]        csr_index,
   input  logic [DIST_W-1:0] csr_write_data
);

   localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int SUM_W  = DIST_W + $clog2(WINDOW_DEPTH);

   // Configuration registers
   logic [DIST_W-1:0] confined_limit_ff;
   logic [DIST_W-1:0] open_limit_ff;
   logic [DIST_W-1:0] front_safe_ff;
   logic [RUN_W-1:0]  stable_needed_ff;

   // Input register
   logic              s1_valid_ff;
   logic [DIST_W-1:0] s1_left_ff;
   logic [DIST_W-1:0] s1_right_ff;
   logic [DIST_W-1:0] s1_front_ff;

   // Qualifier state
   logic [SLOT_W-1:0] slot_ff;
   logic [SLOT_W-1:0] slot_in;
   logic [RUN_W-1:0]  confined_run_ff;
   logic [RUN_W-1:0]  confined_run_in;
   logic [RUN_W-1:0]  open_run_ff;
   logic [RUN_W-1:0]  open_run_in;
   mode_type          mode_ff;
   mode_type          mode_in;

   // Result register
   logic              rsp_valid_ff;
   logic              rsp_mode_ff;
   logic              rsp_mode_changed_ff;

   logic              out_free;
   logic              s1_move;
   logic              req_take;
   logic [SUM_W-1:0]  left_sum;
   logic [SUM_W-1:0]  right_sum;
   logic [SUM_W-1:0]  front_sum;
   logic [SUM_W-1:0]  confined_scaled;
   logic [SUM_W-1:0]  open_scaled;
   logic [SUM_W-1:0]  front_scaled;
   logic              confined;
   logic              open_space;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_take  = req_valid && req_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mode         = rsp_mode_ff;
   assign rsp_mode_changed = rsp_mode_changed_ff;

   // ---------------------------------------------------------------------------
   // Configuration
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         confined_limit_ff <= CONFINED_LIMIT_RESET;
         open_limit_ff     <= OPEN_LIMIT_RESET;
         front_safe_ff     <= FRONT_SAFE_RESET;
         stable_needed_ff  <= STABLE_NEEDED_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_CONFINED_LIMIT: confined_limit_ff <= csr_write_data;
            CSR_OPEN_LIMIT:     open_limit_ff     <= csr_write_data;
            CSR_FRONT_SAFE:     front_safe_ff     <= csr_write_data;
            CSR_STABLE_NEEDED:  stable_needed_ff  <= csr_write_data[RUN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Input register
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_left_ff  <= req_left_range;
         s1_right_ff <= req_right_range;
         s1_front_ff <= req_front_range;
      end
   end

   // ---------------------------------------------------------------------------
   // Window histories
   // ---------------------------------------------------------------------------
   rmq_window #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_left_window (
      .clock    (clock),
      .reset    (reset),
      .update   (s1_move),
      .slot     (slot_ff),
      .sample   (s1_left_ff),
      .sum_next (left_sum)
   );

   rmq_window #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_right_window (
      .clock    (clock),
      .reset    (reset),
      .update   (s1_move),
      .slot     (slot_ff),
      .sample   (s1_right_ff),
      .sum_next (right_sum)
   );

   rmq_window #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_front_window (
      .clock    (clock),
      .reset    (reset),
      .update   (s1_move),
      .slot     (slot_ff),
      .sample   (s1_front_ff),
      .sum_next (front_sum)
   );

   assign slot_in = (slot_ff == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_ff + 1'b1;

   // ---------------------------------------------------------------------------
   // Qualification
   // ---------------------------------------------------------------------------
   // Thresholds are scaled by the window depth so the sums compare exactly.
   assign confined_scaled = SUM_W'(confined_limit_ff) * SUM_W'(WINDOW_DEPTH);
   assign open_scaled     = SUM_W'(open_limit_ff) * SUM_W'(WINDOW_DEPTH);
   assign front_scaled    = SUM_W'(front_safe_ff) * SUM_W'(WINDOW_DEPTH);

   assign confined   = (left_sum < confined_scaled) || (right_sum < confined_scaled) ||
                       (front_sum < front_scaled);
   assign open_space = (left_sum > open_scaled) && (right_sum > open_scaled) &&
                       (front_sum > front_scaled);

   always_comb begin
      confined_run_in = '0;
      open_run_in     = '0;
      mode_in         = mode_ff;
      priority if (confined) begin
         confined_run_in = (confined_run_ff == RUN_MAX) ? RUN_MAX : confined_run_ff + 1'b1;
         if (confined_run_in >= stable_needed_ff) begin
            mode_in = MODE_MAZE;
         end
      end else if (open_space) begin
         open_run_in = (open_run_ff == RUN_MAX) ? RUN_MAX : open_run_ff + 1'b1;
         if (open_run_in >= stable_needed_ff) begin
            mode_in = MODE_LINE;
         end
      end else begin
         confined_run_in = '0;
         open_run_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff         <= '0;
         confined_run_ff <= '0;
         open_run_ff     <= '0;
         mode_ff         <= MODE_LINE;
      end else if (s1_move) begin
         slot_ff         <= slot_in;
         confined_run_ff <= confined_run_in;
         open_run_ff     <= open_run_in;
         mode_ff         <= mode_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_mode_ff         <= mode_in;
         rsp_mode_changed_ff <= (mode_in != mode_ff);
      end
   end

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   `RMQ_ASSERT(a_runs_exclusive, clock, reset,
      !((confined_run_ff != '0) && (open_run_ff != '0)),
      "confined and open runs both nonzero")
   `RMQ_ASSERT(a_changed_matches_mode, clock, reset,
      (!reset && s1_move) |=> (rsp_mode_changed_ff == (mode_ff != $past(mode_ff))),
      "changed flag disagrees with mode update")
   `RMQ_ASSERT(a_mode_reported, clock, reset,
      (!reset && s1_move) |=> (rsp_valid_ff && (rsp_mode_ff == mode_ff)),
      "result mode differs from held mode")
   `RMQ_ASSERT_ALWAYS(a_slot_in_range, clock,
      reset || ({1'b0, slot_ff} < (SLOT_W + 1)'(WINDOW_DEPTH)),
      "write slot beyond window depth")

endmodule
